// ===== sv/bba_pkg.sv =====
package bba_pkg;

   // Field widths of the request, response and control register.
   localparam int TOTAL_W  = 11;
   localparam int BLOCK_W  = 10;
   localparam int STATUS_W = 2;

   // Capacity of the usage map in blocks. The block number fields are ten bits wide,
   // so the map cannot usefully hold more than this.
   localparam int MAX_BLOCKS = 1024;

   // Each word of the usage map covers this many blocks.
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE       = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_CHECK,
      ST_FREE_CHECK
   } state_type;

endpackage

// ===== sv/bitmap_block_allocator.sv =====
// Allocate: the response strobe follows a scan of the map words from word 0 up to the
// word holding the first free block, or up to the last word in range when none is free.
// Free: an out-of-range block is answered from idle, else the word is read, then updated.
// A new item is taken in the cycle its predecessor's response is strobed; the response
// cannot be held off. After reset the map is cleared one word a cycle, with busy high;
// the control register is writable throughout.
module bitmap_block_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_action,
   input  logic [bba_pkg::BLOCK_W-1:0]      req_block_number,
   output logic                             rsp_valid,
   output logic [bba_pkg::BLOCK_W-1:0]      rsp_result_block,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_write_enable,
   input  logic [bba_pkg::TOTAL_W-1:0]      csr_write_data
);

   import bba_pkg::*;

   // The map is held as 64-bit words in a single-port-read RAM. Block numbers are
   // handled internally at CMP_W bits, wide enough for both the word-scaled scan
   // position and the effective total, plus one spare bit.
   localparam int WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CMP_W  = (WORD_W + BIT_W + 1 > TOTAL_W + 1) ? WORD_W + BIT_W + 1
                                                              : TOTAL_W + 1;

   state_type state_ff, state_in;

   logic [TOTAL_W-1:0]  total_ff;
   logic [WORD_W-1:0]   scan_ff, scan_in;
   logic [WORD_W-1:0]   clear_ff, clear_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_block_ff, rsp_block_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Map RAM port signals.
   logic                 ram_wr_en;
   logic [WORD_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // Scan unit: masks the word under test to blocks below the total and finds
   // its lowest clear bit.
   logic [CMP_W-1:0]     eff_total;
   logic [CMP_W-1:0]     word_base;
   logic [CMP_W-1:0]     remain;
   logic                 last_word;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic                 free_found;
   logic [BIT_W-1:0]     free_pos;
   logic [CMP_W-1:0]     alloc_num;
   logic [CMP_W-1:0]     req_blk_ext;
   logic                 req_in_range;

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A programmed total above the capacity of the map counts as the capacity.
   always_comb begin
      if (32'(total_ff) > MAX_BLOCKS) begin
         eff_total = CMP_W'(MAX_BLOCKS);
      end else begin
         eff_total = CMP_W'(total_ff);
      end
   end

   // The scan only reaches a word whose first block lies below the total, so the
   // remainder never goes negative. The word is the last one to try once no more
   // than a full word of blocks is left.
   always_comb begin
      word_base = CMP_W'(scan_ff) << BIT_W;
      remain    = eff_total - word_base;
      last_word = (remain <= CMP_W'(WORD_BITS));
      if (remain >= CMP_W'(WORD_BITS)) begin
         valid_mask = '1;
      end else begin
         valid_mask = (WORD_BITS'(1) << remain[BIT_W-1:0]) - WORD_BITS'(1);
      end
      free_bits = ~ram_rd_data & valid_mask;
   end

   // Priority encoder for the lowest free bit of the word.
   always_comb begin
      free_found = 1'b0;
      free_pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_found = 1'b1;
            free_pos   = BIT_W'(i);
         end
      end
      alloc_num = word_base + CMP_W'(free_pos);
   end

   assign req_blk_ext  = CMP_W'(req_block_number);
   assign req_in_range = (req_blk_ext < eff_total);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         total_ff     <= TOTAL_RESET;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            total_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      blk_ff        <= blk_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      clear_in      = clear_ff;
      blk_in        = blk_ff;
      rsp_valid_in  = 1'b0;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = scan_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = scan_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Every block starts out free.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_ff;
            ram_wr_data = '0;
            if (clear_ff == WORD_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clear_in = clear_ff + WORD_W'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               blk_in = req_block_number;
               if (req_action == ACTION_ALLOC) begin
                  // Fetch the first word; the scan starts on it next cycle.
                  ram_rd_addr = '0;
                  scan_in     = '0;
                  state_in    = ST_ALLOC_CHECK;
               end else if (req_in_range) begin
                  ram_rd_addr = req_blk_ext[WORD_W+BIT_W-1:BIT_W];
                  scan_in     = req_blk_ext[WORD_W+BIT_W-1:BIT_W];
                  state_in    = ST_FREE_CHECK;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_block_in  = req_block_number;
                  rsp_status_in = STATUS_RANGE;
               end
            end
         end

         ST_ALLOC_CHECK: begin
            // The next word is fetched while this one is examined, so the scan
            // covers one word per cycle.
            ram_rd_addr = scan_ff + WORD_W'(1);
            if (free_found) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = scan_ff;
               ram_wr_data   = ram_rd_data | (WORD_BITS'(1) << free_pos);
               rsp_valid_in  = 1'b1;
               rsp_block_in  = alloc_num[BLOCK_W-1:0];
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end else if (last_word) begin
               rsp_valid_in  = 1'b1;
               rsp_block_in  = '0;
               rsp_status_in = STATUS_FULL;
               state_in      = ST_IDLE;
            end else begin
               scan_in = scan_ff + WORD_W'(1);
            end
         end

         ST_FREE_CHECK: begin
            rsp_valid_in = 1'b1;
            rsp_block_in = blk_ff;
            state_in     = ST_IDLE;
            if (ram_rd_data[blk_ff[BIT_W-1:0]]) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = scan_ff;
               ram_wr_data   = ram_rd_data & ~(WORD_BITS'(1) << blk_ff[BIT_W-1:0]);
               rsp_status_in = STATUS_OK;
            end else begin
               rsp_status_in = STATUS_DOUBLE_FREE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== sv/bba_ram.sv =====
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
